[hw/rtl/grid_dda_raycast_column_unit_defines.svh]
// Assertion macros for the column raycaster.
`ifndef GRID_DDA_RAYCAST_COLUMN_UNIT_DEFINES_SVH
`define GRID_DDA_RAYCAST_COLUMN_UNIT_DEFINES_SVH
`ifndef SYNTH
`define GDR_ASSERT_IMPL(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("%m failed");
`define GDR_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("%m failed");
`else
`define GDR_ASSERT_IMPL(label, clk, rst, cond)
`define GDR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[hw/rtl/gdr_pkg.sv]
`default_nettype none
package gdr_pkg;
  localparam int unsigned CellFrac = 12;
  localparam int unsigned OffW = 20;
  localparam int unsigned RayW = 20;
  localparam int unsigned ProdW = OffW + RayW;
  localparam int unsigned NumW = 16;
  localparam int unsigned DenW = 19;
  localparam int unsigned LhW = 14;
endpackage
`default_nettype wire

[hw/rtl/grid_dda_raycast_column_unit.sv]
`default_nettype none
// Wall-column raycaster. Each input transfer names a screen column and the
// viewer's position, direction and camera plane; the unit forms the ray for
// that column, walks the bitmap grid cell by cell with exact DDA (one shared
// 20x20 multiplier compares the two side distances, one product per cycle)
// and on a wall hit divides once with a bit-serial divider to get the slice
// height. Set-up runs through the accept state, then cam and the two ray
// components; the walk takes at most 2*MAP_SIZE+2 grid steps, and a skipped
// ray or a short walk reaches the output without the divide or with fewer
// steps.
// The unit holds one item at a time; tready on the input is low while an
// item is in work or its result waits on the output. The wall bitmap is
// written through cfg_valid/cfg_ready while the unit is idle.
`include "grid_dda_raycast_column_unit_defines.svh"
module grid_dda_raycast_column_unit #(
  parameter int unsigned MAP_SIZE = 8,
  parameter int unsigned SCREEN_W = 1280,
  parameter int unsigned SCREEN_H = 720
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // column[10:0], pos_x[25:11], pos_y[40:26], dir_x[56:41], dir_y[72:57],
  // plane_x[88:73], plane_y[104:89], zero fill to 112 bits
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_column[10:0], draw_start[20:11], draw_end[30:21], shaded[31],
  // skipped[32], hit[33], zero fill to 40 bits
  output logic [39:0]       m_axis_tdata
);
  localparam int unsigned PW = gdr_pkg::ProdW;
  localparam int unsigned QW = 32;
  localparam int unsigned CamShift = 23;
  localparam longint unsigned CamRecip =
    ((64'd1 << (CamShift + 17)) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W);
  localparam logic [2:0] S_IDLE = 3'd0, S_CAMX = 3'd1, S_CAMY = 3'd2,
                         S_SETUP = 3'd3, S_MA = 3'd4, S_MB = 3'd5,
                         S_DIV = 3'd6, S_OUT = 3'd7;

  logic [2:0]  state;
  logic [63:0] wall_bitmap;
  logic [10:0] column;
  logic [14:0] pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic signed [18:0] cam;
  logic signed [gdr_pkg::RayW-1:0] ray_x, ray_y;
  logic [gdr_pkg::OffW-1:0] off_x, off_y;
  logic signed [4:0] mx, my;
  logic [4:0]  steps;
  logic        xside;
  logic [PW-1:0] prod_a;
  logic signed [35:0] cam_prod;
  logic        div_start, div_done;
  logic [QW-1:0] div_quot;
  logic [QW-1:0] div_num;
  logic [gdr_pkg::NumW+1:0] numv;
  logic [10:0] out_column;
  logic [9:0]  draw_start, draw_end;
  logic        shaded, skipped, hit;

  // cam for this column, exact floor of 2*col*65536/SCREEN_W, by multiplying
  // with a rounded-up reciprocal; the error stays below one step of the
  // quotient for every 11-bit column.
  logic [17:0] cam_u;
  assign cam_u = 18'((64'(column) * CamRecip) >> CamShift);

  // plane*cam in the set-up cycles; the side compare products come from the
  // walk multiplier below.
  logic [19:0] ax, ay;
  assign ax = ray_x[19] ? 20'(-ray_x) : 20'(ray_x);
  assign ay = ray_y[19] ? 20'(-ray_y) : 20'(ray_y);
  logic [gdr_pkg::OffW-1:0] m_l;
  logic [19:0] m_r;
  always_comb begin
    m_l = (state == S_MA) ? off_x : off_y;
    m_r = (state == S_MA) ? ay : ax;
  end
  assign cam_prod = ((state == S_CAMY) ? plane_x : plane_y) * cam;
  logic [PW-1:0] mprod;
  assign mprod = PW'(m_l) * PW'(m_r);

  logic signed [19:0] cam_term;
  assign cam_term = 20'(cam_prod >>> 16);

  logic xside_next;
  assign xside_next = prod_a < mprod;
  logic signed [5:0] nx, ny;
  assign nx = xside_next ? 6'(mx) + (ray_x[19] ? -6'sd1 : 6'sd1) : 6'(mx);
  assign ny = xside_next ? 6'(my) : 6'(my) + (ray_y[19] ? -6'sd1 : 6'sd1);
  logic out_map;
  assign out_map = nx < 0 || ny < 0 || nx >= $signed(6'(MAP_SIZE)) ||
                   ny >= $signed(6'(MAP_SIZE));
  logic wall;
  assign wall = wall_bitmap[6'(ny[2:0]) * 6'd8 + 6'(nx[2:0])];

  // wall distance numerator; boundary of the entered cell on the near side
  logic signed [17:0] bnd;
  always_comb begin
    if (xside) bnd = 18'(mx) * 18'sd4096 - 18'(pos_x) + (ray_x[19] ? 18'sd4096 : 18'sd0);
    else       bnd = 18'(my) * 18'sd4096 - 18'(pos_y) + (ray_y[19] ? 18'sd4096 : 18'sd0);
    numv = bnd[17] ? 18'(-bnd) : 18'(bnd);
  end
  assign div_num = QW'(SCREEN_H) * QW'(xside ? ax : ay);

  gdr_divider #(.NW(QW), .DW(gdr_pkg::NumW + 4)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_num),
    .denom((gdr_pkg::NumW + 4)'({numv, 2'b00})), .done(div_done), .quot(div_quot)
  );

  logic [QW-1:0] lh_sat;
  assign lh_sat = (div_quot > QW'(2 * SCREEN_H)) ? QW'(2 * SCREEN_H) : div_quot;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {6'd0, hit, skipped, shaded, draw_end, draw_start, out_column};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wall_bitmap <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) wall_bitmap <= cfg_data;
          if (s_axis_tvalid) begin
            column <= s_axis_tdata[10:0];
            pos_x <= s_axis_tdata[25:11];
            pos_y <= s_axis_tdata[40:26];
            dir_x <= s_axis_tdata[56:41];
            dir_y <= s_axis_tdata[72:57];
            plane_x <= s_axis_tdata[88:73];
            plane_y <= s_axis_tdata[104:89];
            state <= S_CAMX;
          end
        end
        S_CAMX: begin
          cam <= $signed({1'b0, cam_u}) - 19'sd65536;
          state <= S_CAMY;
        end
        S_CAMY: begin
          ray_x <= 20'(dir_x) + cam_term;
          state <= S_SETUP;
        end
        S_SETUP: begin
          ray_y <= 20'(dir_y) + cam_term;
          mx <= 5'(pos_x[14:12]);
          my <= 5'(pos_y[14:12]);
          steps <= '0;
          out_column <= column;
          draw_start <= '0; draw_end <= '0; shaded <= 1'b0; hit <= 1'b0;
          skipped <= 1'b0;
          if (ray_x == 0 || (20'(dir_y) + cam_term) == 0) begin
            skipped <= 1'b1;
            state <= S_OUT;
          end else begin
            off_x <= ray_x[19] ? 20'(pos_x[11:0]) : 20'(13'd4096 - 13'(pos_x[11:0]));
            off_y <= (20'(dir_y) + cam_term) < 0 ? 20'(pos_y[11:0])
                     : 20'(13'd4096 - 13'(pos_y[11:0]));
            state <= S_MA;
          end
        end
        S_MA: begin
          prod_a <= mprod;
          state <= S_MB;
        end
        S_MB: begin
          xside <= xside_next;
          mx <= 5'(nx); my <= 5'(ny);
          if (xside_next) off_x <= off_x + 20'd4096;
          else            off_y <= off_y + 20'd4096;
          steps <= steps + 1'b1;
          if (out_map) state <= S_OUT;
          else if (wall) begin
            div_start <= 1'b1;
            state <= S_DIV;
          end else if (steps == 5'(2 * MAP_SIZE + 1)) state <= S_OUT;
          else state <= S_MA;
        end
        S_DIV: begin
          if (div_done) begin
            hit <= 1'b1;
            shaded <= xside;
            draw_start <= (lh_sat / 2 >= QW'(SCREEN_H / 2)) ? 10'd0
                          : 10'(QW'(SCREEN_H / 2) - lh_sat / 2);
            draw_end <= (lh_sat / 2 + QW'(SCREEN_H / 2) > QW'(SCREEN_H - 1))
                        ? 10'(SCREEN_H - 1) : 10'(lh_sat / 2 + QW'(SCREEN_H / 2));
            state <= S_OUT;
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `GDR_ASSERT_IMPL(a_skip_no_hit, clk, rst, !(m_axis_tvalid && skipped && hit))
  `GDR_ASSERT_IMPL(a_shade_needs_hit, clk, rst, !(m_axis_tvalid && shaded && !hit))
  `GDR_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire

[hw/rtl/gdr_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module gdr_divider #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] numer,
  input  wire logic [DW-1:0] denom,
  output logic               done,
  output logic [NW-1:0]      quot
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [CW-1:0] count;
  logic          busy;
  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign fits = trial >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(NW);
        q <= numer;
        rem <= '0;
      end else if (busy) begin
        rem <= fits ? trial - {1'b0, denom} : trial;
        q <= {q[NW-2:0], fits};
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quot = q;
endmodule
`default_nettype wire
